/* rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an expression holds at every clock edge outside reset.
`define MFQS_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// Checks that a condition implies a consequence in the same cycle.
`define MFQS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Checks that a condition implies a consequence in the next cycle.
`define MFQS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* rtl/mfqs_pkg.sv */
package mfqs_pkg;

   localparam int MaxProc = 8;
   localparam int SlotW   = $clog2(MaxProc);
   localparam int LenW    = $clog2(MaxProc + 1);

   localparam logic [1:0] QueueOne     = 2'd0;
   localparam logic [1:0] QueueTwo     = 2'd1;
   localparam logic [1:0] QueueThree   = 2'd2;
   localparam logic [1:0] QueueBlocked = 2'd3;

   localparam logic [1:0] KindRun  = 2'd0;
   localparam logic [1:0] KindBlk  = 2'd1;
   localparam logic [1:0] KindLoad = 2'd2;

   localparam logic [2:0] EvIdle     = 3'd0;
   localparam logic [2:0] EvRan      = 3'd1;
   localparam logic [2:0] EvFinished = 3'd2;
   localparam logic [2:0] EvToTwo    = 3'd3;
   localparam logic [2:0] EvToThree  = 3'd4;
   localparam logic [2:0] EvRotated  = 3'd5;
   localparam logic [2:0] EvToIo     = 3'd6;
   localparam logic [2:0] EvWaiting  = 3'd1;
   localparam logic [2:0] EvBackOne  = 3'd3;
   localparam logic [2:0] EvBackTwo  = 3'd4;
   localparam logic [2:0] EvBackThree = 3'd5;

   localparam logic [2:0] RegQuantumOne   = 3'd0;
   localparam logic [2:0] RegQuantumTwo   = 3'd1;
   localparam logic [2:0] RegQuantumThree = 3'd2;
   localparam logic [2:0] RegBoostPeriod  = 3'd3;
   localparam logic [2:0] RegIoDuration   = 3'd4;
   localparam logic [2:0] RegProcessCount = 3'd5;

   localparam int DivHundredMul   = 5243;
   localparam int DivHundredShift = 19;

   typedef struct packed {
      logic [7:0]  total;
      logic [6:0]  io_pct;
      logic [15:0] arrival;
      logic [7:0]  remaining;
      logic [15:0] used;
      logic [15:0] slice;
      logic [1:0]  level;
      logic [7:0]  io_left;
      logic        responded;
      logic [15:0] response;
   } proc_row_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  pid;
      logic [2:0]  ev;
      logic [15:0] resp;
      logic [15:0] comp;
      logic [15:0] tat;
   } result_type;

   typedef logic [MaxProc-1:0][SlotW-1:0] queue_type;

   function automatic queue_type q_pop(queue_type q);
      return queue_type'(q >> SlotW);
   endfunction

   function automatic queue_type q_push(queue_type q, logic [LenW-1:0] len,
                                        logic [SlotW-1:0] p);
      queue_type r;
      r = q;
      if (len < LenW'(MaxProc)) begin
         r[len[SlotW-1:0]] = p;
      end
      return r;
   endfunction

   function automatic queue_type q_ins2(queue_type q, logic [LenW-1:0] len,
                                        logic [SlotW-1:0] p);
      queue_type r;
      r = q;
      if (len == '0) begin
         r[0] = p;
      end else if (len < LenW'(MaxProc)) begin
         for (int k = MaxProc - 1; k >= 2; k--) begin
            r[k] = q[k-1];
         end
         r[1] = p;
      end
      return r;
   endfunction

   function automatic logic [LenW-1:0] len_pop(logic [LenW-1:0] l);
      return (l != '0) ? l - LenW'(1) : l;
   endfunction

   function automatic logic [LenW-1:0] len_push(logic [LenW-1:0] l);
      return (l < LenW'(MaxProc)) ? l + LenW'(1) : l;
   endfunction

   function automatic logic [15:0] sat16(logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

endpackage

/* rtl/mfqs_ram.sv */
module mfqs_ram #(
   parameter int Width = 8,
   parameter int Depth = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

/* rtl/multilevel_feedback_queue_scheduler.sv */
// Three-level feedback queue scheduler. A load beat fills one process slot and is acknowledged
// in the next cycle. A tick beat admits arrivals, runs the head of the highest busy level,
// services the head of the blocked queue and applies the periodic boost, then returns a run
// report and a blocked report. The process table sits in one single-port-read memory, so the
// arrival scan reads each slot in turn, the run step does a 17-step modulo of the draw by the
// instruction count, and the boost check does a modulo of the tick plus one by the period; a
// boost moves processes up one at a time and then rewrites the row of each process in queue one
// and in the blocked queue. The next beat is taken once the last report of the current one has
// been delivered.
`include "assert_macros.svh"

module multilevel_feedback_queue_scheduler (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // slot[2:0], count[10:3], io_pct[17:11], arrival[33:18], draw[49:34]
   input  logic [55:0] req_tdata,
   // op[0]
   input  logic [0:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // pid[2:0], event[5:3], response[21:6], finish_tick[37:22],
   // turnaround[53:38], boost[54], all_done[55]
   output logic [55:0] rsp_tdata,
   // kind[1:0]
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int SlotW = mfqs_pkg::SlotW;
   localparam int LenW  = mfqs_pkg::LenW;
   localparam int RowW  = $bits(mfqs_pkg::proc_row_type);

   typedef enum logic [4:0] {
      StIdle, StScanRd, StScanChk, StRunSel, StRunWait, StRunMul, StRunMod, StRunUpd,
      StBlkSel, StBlkWait, StBlkUpd, StBstStart, StBstMod, StBstMove, StBstRd0, StBstWr0,
      StBstRd3, StBstWr3, StFin, StOutRun, StOutBlk
   } state_type;

   logic [7:0]  q1_ff, q2_ff, q3_ff, iod_ff;
   logic [15:0] period_ff;
   logic [3:0]  pc_ff;

   state_type                    state_ff, state_in;
   logic [LenW-1:0]              idx_ff, idx_in;
   logic [1:0]                   w_ff, w_in;
   mfqs_pkg::proc_row_type       cur_ff, cur_in;
   logic [15:0]                  draw_ff, draw_in;
   logic [14:0]                  prod_ff, prod_in;
   logic [8:0]                   thr_ff, thr_in;
   logic [16:0]                  mod_num_ff, mod_num_in;
   logic [15:0]                  mod_rem_ff, mod_rem_in;
   logic [15:0]                  mod_div_ff, mod_div_in;
   logic [4:0]                   mod_cnt_ff, mod_cnt_in;
   mfqs_pkg::queue_type          q_ff [4];
   mfqs_pkg::queue_type          q_in [4];
   logic [LenW-1:0]              len_ff [4];
   logic [LenW-1:0]              len_in [4];
   logic [15:0]                  tick_ff, tick_in;
   logic [3:0]                   fin_ff, fin_in;
   logic [mfqs_pkg::MaxProc-1:0] loaded_ff, loaded_in;
   mfqs_pkg::result_type         res_run_ff, res_run_in, res_blk_ff, res_blk_in;
   logic                         boost_ff, boost_in;
   logic                         load_ff, load_in;

   logic                         ram_we;
   logic [SlotW-1:0]             ram_waddr, ram_raddr;
   mfqs_pkg::proc_row_type       ram_wdata, ram_rdata;

   logic [16:0]                  mod_t;
   logic [15:0]                  mod_next;
   logic [27:0]                  thr_prod;
   logic [15:0]                  resp_calc, tat_calc, tick_diff;
   logic [15:0]                  sum_q12;
   logic [LenW+1:0]              occ_sum;
   logic                         all_done;
   logic                         csr_wr;

   mfqs_ram #(.Width(RowW), .Depth(mfqs_pkg::MaxProc)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         q1_ff     <= 8'd5;
         q2_ff     <= 8'd10;
         q3_ff     <= 8'd20;
         period_ff <= 16'd40;
         iod_ff    <= 8'd5;
         pc_ff     <= 4'd0;
      end else if (csr_wr) begin
         unique case (csr_paddr[4:2])
            mfqs_pkg::RegQuantumOne:   q1_ff     <= csr_pwdata[7:0];
            mfqs_pkg::RegQuantumTwo:   q2_ff     <= csr_pwdata[7:0];
            mfqs_pkg::RegQuantumThree: q3_ff     <= csr_pwdata[7:0];
            mfqs_pkg::RegBoostPeriod:  period_ff <= csr_pwdata[15:0];
            mfqs_pkg::RegIoDuration:   iod_ff    <= csr_pwdata[7:0];
            mfqs_pkg::RegProcessCount: pc_ff     <= csr_pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[4:2])
         mfqs_pkg::RegQuantumOne:   csr_prdata = {24'd0, q1_ff};
         mfqs_pkg::RegQuantumTwo:   csr_prdata = {24'd0, q2_ff};
         mfqs_pkg::RegQuantumThree: csr_prdata = {24'd0, q3_ff};
         mfqs_pkg::RegBoostPeriod:  csr_prdata = {16'd0, period_ff};
         mfqs_pkg::RegIoDuration:   csr_prdata = {24'd0, iod_ff};
         mfqs_pkg::RegProcessCount: csr_prdata = {28'd0, pc_ff};
         default:                   csr_prdata = 32'd0;
      endcase
   end

   assign mod_t    = {mod_rem_ff, mod_num_ff[16]};
   assign mod_next = (mod_t >= {1'b0, mod_div_ff}) ? 16'(mod_t - {1'b0, mod_div_ff})
                                                   : mod_t[15:0];
   assign thr_prod = {13'd0, prod_ff} * 28'(mfqs_pkg::DivHundredMul);
   assign tick_diff = tick_ff - cur_ff.arrival;
   assign resp_calc = (tick_ff >= cur_ff.arrival) ? tick_diff : 16'd0;
   assign tat_calc  = (tick_ff < cur_ff.arrival) ? 16'd0 :
                      (tick_diff == 16'hFFFF) ? 16'hFFFF : tick_diff + 16'd1;
   assign sum_q12   = {7'd0, {1'b0, q1_ff} + {1'b0, q2_ff}};
   assign all_done  = fin_ff >= pc_ff;

   always_comb begin
      mfqs_pkg::proc_row_type row;
      logic [SlotW-1:0]       pv;
      logic [1:0]             tq;
      state_in   = state_ff;
      idx_in     = idx_ff;
      w_in       = w_ff;
      cur_in     = cur_ff;
      draw_in    = draw_ff;
      prod_in    = prod_ff;
      thr_in     = thr_ff;
      mod_num_in = mod_num_ff;
      mod_rem_in = mod_rem_ff;
      mod_div_in = mod_div_ff;
      mod_cnt_in = mod_cnt_ff;
      q_in       = q_ff;
      len_in     = len_ff;
      tick_in    = tick_ff;
      fin_in     = fin_ff;
      loaded_in  = loaded_ff;
      res_run_in = res_run_ff;
      res_blk_in = res_blk_ff;
      boost_in   = boost_ff;
      load_in    = load_ff;
      ram_we     = 1'b0;
      ram_waddr  = '0;
      ram_wdata  = cur_ff;
      ram_raddr  = '0;
      row        = cur_ff;
      pv         = res_run_ff.pid[SlotW-1:0];
      tq         = mfqs_pkg::QueueOne;

      unique case (state_ff)
         StIdle: begin
            if (req_tvalid) begin
               boost_in   = 1'b0;
               res_run_in = '0;
               res_blk_in = '0;
               res_blk_in.kind = mfqs_pkg::KindBlk;
               if (req_tuser[0] == 1'b0) begin
                  pv = req_tdata[SlotW-1:0];
                  res_run_in.kind = mfqs_pkg::KindLoad;
                  res_run_in.pid  = req_tdata[2:0];
                  load_in = 1'b1;
                  if (!loaded_ff[pv]) begin
                     loaded_in[pv] = 1'b1;
                     row = '0;
                     row.total     = (req_tdata[10:3] != 8'd0) ? req_tdata[10:3] : 8'd1;
                     row.io_pct    = req_tdata[17:11];
                     row.arrival   = req_tdata[33:18];
                     row.remaining = row.total;
                     ram_we    = 1'b1;
                     ram_waddr = pv;
                     ram_wdata = row;
                  end
                  state_in = StOutRun;
               end else begin
                  res_run_in.kind = mfqs_pkg::KindRun;
                  draw_in  = req_tdata[49:34];
                  load_in  = 1'b0;
                  idx_in   = '0;
                  state_in = StScanRd;
               end
            end
         end
         StScanRd: begin
            ram_raddr = idx_ff[SlotW-1:0];
            state_in  = StScanChk;
         end
         StScanChk: begin
            pv  = idx_ff[SlotW-1:0];
            row = ram_rdata;
            if (loaded_ff[pv] && row.level == 2'd0 && row.arrival == tick_ff) begin
               q_in[mfqs_pkg::QueueOne] = mfqs_pkg::q_push(q_ff[mfqs_pkg::QueueOne],
                                                           len_ff[mfqs_pkg::QueueOne], pv);
               len_in[mfqs_pkg::QueueOne] = mfqs_pkg::len_push(len_ff[mfqs_pkg::QueueOne]);
               row.level     = 2'd1;
               row.remaining = row.total;
               ram_we    = 1'b1;
               ram_waddr = pv;
               ram_wdata = row;
            end
            if (pv == SlotW'(mfqs_pkg::MaxProc - 1)) begin
               state_in = StRunSel;
            end else begin
               idx_in   = idx_ff + LenW'(1);
               state_in = StScanRd;
            end
         end
         StRunSel: begin
            priority if (len_ff[mfqs_pkg::QueueOne] != '0) begin
               tq = mfqs_pkg::QueueOne;
            end else if (len_ff[mfqs_pkg::QueueTwo] != '0) begin
               tq = mfqs_pkg::QueueTwo;
            end else begin
               tq = mfqs_pkg::QueueThree;
            end
            if (len_ff[tq] != '0) begin
               w_in       = tq;
               ram_raddr  = q_ff[tq][0];
               res_run_in.pid = 3'(q_ff[tq][0]);
               state_in   = StRunWait;
            end else begin
               state_in = StBlkSel;
            end
         end
         StRunWait: begin
            cur_in   = ram_rdata;
            state_in = StRunMul;
         end
         StRunMul: begin
            prod_in    = {8'd0, cur_ff.io_pct} * {7'd0, cur_ff.total};
            mod_num_in = {1'b0, draw_ff};
            mod_div_in = {8'd0, cur_ff.total};
            mod_rem_in = '0;
            mod_cnt_in = '0;
            state_in   = StRunMod;
         end
         StRunMod: begin
            thr_in     = thr_prod[mfqs_pkg::DivHundredShift +: 9];
            mod_rem_in = mod_next;
            mod_num_in = mod_num_ff << 1;
            mod_cnt_in = mod_cnt_ff + 5'd1;
            if (mod_cnt_ff == 5'd16) begin
               state_in = StRunUpd;
            end
         end
         StRunUpd: begin
            if (!row.responded) begin
               row.responded = 1'b1;
               row.response  = resp_calc;
            end
            if (mod_rem_ff >= {7'd0, thr_ff}) begin
               if (row.remaining != 8'd0) begin
                  row.remaining = row.remaining - 8'd1;
               end
               row.used = mfqs_pkg::sat16(row.used);
               if (w_ff == mfqs_pkg::QueueThree) begin
                  row.slice = mfqs_pkg::sat16(row.slice);
               end
               priority if (row.remaining == 8'd0) begin
                  q_in[w_ff]   = mfqs_pkg::q_pop(q_ff[w_ff]);
                  len_in[w_ff] = mfqs_pkg::len_pop(len_ff[w_ff]);
                  res_run_in.ev   = mfqs_pkg::EvFinished;
                  res_run_in.resp = row.response;
                  res_run_in.comp = tick_ff;
                  res_run_in.tat  = tat_calc;
                  fin_in = (fin_ff < 4'd15) ? fin_ff + 4'd1 : fin_ff;
               end else if (w_ff == mfqs_pkg::QueueOne && row.used >= {8'd0, q1_ff}) begin
                  tq = mfqs_pkg::QueueTwo;
                  row.level = 2'd2;
                  res_run_in.ev = mfqs_pkg::EvToTwo;
               end else if (w_ff == mfqs_pkg::QueueTwo && row.used >= sum_q12) begin
                  tq = mfqs_pkg::QueueThree;
                  row.level = 2'd3;
                  row.slice = '0;
                  res_run_in.ev = mfqs_pkg::EvToThree;
               end else if (w_ff == mfqs_pkg::QueueThree && row.slice >= {8'd0, q3_ff}) begin
                  tq = mfqs_pkg::QueueThree;
                  row.slice = '0;
                  res_run_in.ev = mfqs_pkg::EvRotated;
               end else begin
                  res_run_in.ev = mfqs_pkg::EvRan;
               end
            end else begin
               tq = mfqs_pkg::QueueBlocked;
               row.io_left = iod_ff;
               res_run_in.ev = mfqs_pkg::EvToIo;
            end
            if (res_run_in.ev != mfqs_pkg::EvRan && res_run_in.ev != mfqs_pkg::EvFinished) begin
               q_in[w_ff]   = mfqs_pkg::q_pop(q_ff[w_ff]);
               len_in[w_ff] = mfqs_pkg::len_pop(len_ff[w_ff]);
               q_in[tq]     = mfqs_pkg::q_push(q_in[tq], len_in[tq], pv);
               len_in[tq]   = mfqs_pkg::len_push(len_in[tq]);
            end
            ram_we    = 1'b1;
            ram_waddr = pv;
            ram_wdata = row;
            state_in  = StBlkSel;
         end
         StBlkSel: begin
            if (len_ff[mfqs_pkg::QueueBlocked] != '0) begin
               ram_raddr = q_ff[mfqs_pkg::QueueBlocked][0];
               res_blk_in.pid = 3'(q_ff[mfqs_pkg::QueueBlocked][0]);
               state_in = StBlkWait;
            end else begin
               state_in = StBstStart;
            end
         end
         StBlkWait: begin
            cur_in   = ram_rdata;
            state_in = StBlkUpd;
         end
         StBlkUpd: begin
            pv = res_blk_ff.pid[SlotW-1:0];
            row.used = mfqs_pkg::sat16(row.used);
            if (row.io_left <= 8'd1) begin
               row.io_left = 8'd0;
               q_in[mfqs_pkg::QueueBlocked] = mfqs_pkg::q_pop(q_ff[mfqs_pkg::QueueBlocked]);
               len_in[mfqs_pkg::QueueBlocked] =
                  mfqs_pkg::len_pop(len_ff[mfqs_pkg::QueueBlocked]);
               if (row.remaining <= 8'd1) begin
                  row.remaining   = 8'd0;
                  res_blk_in.ev   = mfqs_pkg::EvFinished;
                  res_blk_in.resp = row.response;
                  res_blk_in.comp = tick_ff;
                  res_blk_in.tat  = tat_calc;
                  fin_in = (fin_ff < 4'd15) ? fin_ff + 4'd1 : fin_ff;
               end else begin
                  row.remaining = row.remaining - 8'd1;
                  priority if (row.used > sum_q12) begin
                     tq = mfqs_pkg::QueueThree;
                     row.slice = '0;
                     res_blk_in.ev = mfqs_pkg::EvBackThree;
                  end else if (row.used > {8'd0, q1_ff}) begin
                     tq = mfqs_pkg::QueueTwo;
                     res_blk_in.ev = mfqs_pkg::EvBackTwo;
                  end else begin
                     tq = mfqs_pkg::QueueOne;
                     res_blk_in.ev = mfqs_pkg::EvBackOne;
                  end
                  if (row.level == tq + 2'd1) begin
                     q_in[tq] = mfqs_pkg::q_ins2(q_ff[tq], len_ff[tq], pv);
                  end else begin
                     q_in[tq] = mfqs_pkg::q_push(q_ff[tq], len_ff[tq], pv);
                     row.level = tq + 2'd1;
                  end
                  len_in[tq] = mfqs_pkg::len_push(len_ff[tq]);
               end
            end else begin
               row.io_left   = row.io_left - 8'd1;
               res_blk_in.ev = mfqs_pkg::EvWaiting;
            end
            ram_we    = 1'b1;
            ram_waddr = pv;
            ram_wdata = row;
            state_in  = StBstStart;
         end
         StBstStart: begin
            if (period_ff == 16'd0) begin
               state_in = StFin;
            end else begin
               mod_num_in = {1'b0, tick_ff} + 17'd1;
               mod_div_in = period_ff;
               mod_rem_in = '0;
               mod_cnt_in = '0;
               state_in   = StBstMod;
            end
         end
         StBstMod: begin
            mod_rem_in = mod_next;
            mod_num_in = mod_num_ff << 1;
            mod_cnt_in = mod_cnt_ff + 5'd1;
            if (mod_cnt_ff == 5'd16) begin
               if (mod_next == 16'd0) begin
                  boost_in = 1'b1;
                  state_in = StBstMove;
               end else begin
                  state_in = StFin;
               end
            end
         end
         StBstMove: begin
            priority if (len_ff[mfqs_pkg::QueueTwo] != '0) begin
               tq = mfqs_pkg::QueueTwo;
            end else begin
               tq = mfqs_pkg::QueueThree;
            end
            if (len_ff[tq] != '0) begin
               q_in[tq]   = mfqs_pkg::q_pop(q_ff[tq]);
               len_in[tq] = mfqs_pkg::len_pop(len_ff[tq]);
               q_in[mfqs_pkg::QueueOne] = mfqs_pkg::q_push(q_ff[mfqs_pkg::QueueOne],
                                                           len_ff[mfqs_pkg::QueueOne],
                                                           q_ff[tq][0]);
               len_in[mfqs_pkg::QueueOne] = mfqs_pkg::len_push(len_ff[mfqs_pkg::QueueOne]);
            end else begin
               idx_in   = '0;
               state_in = StBstRd0;
            end
         end
         StBstRd0: begin
            if (idx_ff < len_ff[mfqs_pkg::QueueOne]) begin
               ram_raddr = q_ff[mfqs_pkg::QueueOne][idx_ff[SlotW-1:0]];
               state_in  = StBstWr0;
            end else begin
               idx_in   = '0;
               state_in = StBstRd3;
            end
         end
         StBstWr0: begin
            row       = ram_rdata;
            row.used  = '0;
            row.level = 2'd1;
            ram_we    = 1'b1;
            ram_waddr = q_ff[mfqs_pkg::QueueOne][idx_ff[SlotW-1:0]];
            ram_wdata = row;
            idx_in    = idx_ff + LenW'(1);
            state_in  = StBstRd0;
         end
         StBstRd3: begin
            if (idx_ff < len_ff[mfqs_pkg::QueueBlocked]) begin
               ram_raddr = q_ff[mfqs_pkg::QueueBlocked][idx_ff[SlotW-1:0]];
               state_in  = StBstWr3;
            end else begin
               state_in = StFin;
            end
         end
         StBstWr3: begin
            row       = ram_rdata;
            row.used  = '0;
            ram_we    = 1'b1;
            ram_waddr = q_ff[mfqs_pkg::QueueBlocked][idx_ff[SlotW-1:0]];
            ram_wdata = row;
            idx_in    = idx_ff + LenW'(1);
            state_in  = StBstRd3;
         end
         StFin: begin
            tick_in  = mfqs_pkg::sat16(tick_ff);
            state_in = StOutRun;
         end
         StOutRun: begin
            if (rsp_tready) begin
               state_in = load_ff ? StIdle : StOutBlk;
            end
         end
         StOutBlk: begin
            if (rsp_tready) begin
               state_in = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= StIdle;
         len_ff    <= '{default: '0};
         tick_ff   <= '0;
         fin_ff    <= '0;
         loaded_ff <= '0;
         boost_ff  <= 1'b0;
         load_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         len_ff    <= len_in;
         tick_ff   <= tick_in;
         fin_ff    <= fin_in;
         loaded_ff <= loaded_in;
         boost_ff  <= boost_in;
         load_ff   <= load_in;
      end
      idx_ff     <= idx_in;
      w_ff       <= w_in;
      cur_ff     <= cur_in;
      draw_ff    <= draw_in;
      prod_ff    <= prod_in;
      thr_ff     <= thr_in;
      mod_num_ff <= mod_num_in;
      mod_rem_ff <= mod_rem_in;
      mod_div_ff <= mod_div_in;
      mod_cnt_ff <= mod_cnt_in;
      q_ff       <= q_in;
      res_run_ff <= res_run_in;
      res_blk_ff <= res_blk_in;
   end

   mfqs_pkg::result_type res_out;

   assign req_tready = (state_ff == StIdle);
   assign rsp_tvalid = (state_ff == StOutRun) || (state_ff == StOutBlk);
   assign res_out    = (state_ff == StOutBlk) ? res_blk_ff : res_run_ff;
   assign rsp_tlast  = (state_ff == StOutBlk) || ((state_ff == StOutRun) && load_ff);
   assign rsp_tuser  = res_out.kind;
   assign rsp_tdata  = {all_done, boost_ff, res_out.tat, res_out.comp, res_out.resp,
                        res_out.ev, res_out.pid};

   assign occ_sum = (LenW+2)'(len_ff[0]) + (LenW+2)'(len_ff[1]) +
                    (LenW+2)'(len_ff[2]) + (LenW+2)'(len_ff[3]);

   `MFQS_ASSERT_ALWAYS(a_occupancy, clock, reset, occ_sum <= (LenW+2)'(mfqs_pkg::MaxProc))
   `MFQS_ASSERT_IMPLY(a_no_overlap, clock, reset, rsp_tvalid, !req_tready)
   `MFQS_ASSERT_NEXT(a_back_idle, clock, reset, rsp_tvalid && rsp_tready && rsp_tlast, req_tready)

endmodule
